// ===== design/c_subset_tokenizer_top_defines.svh =====
// Assertion helpers for the tokenizer; they expect clk and rst_n in scope.
`ifndef C_SUBSET_TOKENIZER_TOP_DEFINES_SVH
`define C_SUBSET_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cst_pkg.sv =====
`default_nettype none
package cst_pkg;

  localparam int LINE_COUNTER_BITS_DEF   = 16;
  localparam int OFFSET_COUNTER_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF         = 8;

  localparam int RESULT_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_CONST = 2'd2,
    MODE_HALT  = 2'd3
  } mode_t;

  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_CONST  = 4'd1;
  localparam logic [3:0] KIND_INT    = 4'd2;
  localparam logic [3:0] KIND_RETURN = 4'd3;
  localparam logic [3:0] KIND_VOID   = 4'd4;
  localparam logic [3:0] KIND_SEMI   = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_LPAREN = 4'd8;
  localparam logic [3:0] KIND_RPAREN = 4'd9;
  localparam logic [3:0] KIND_END    = 4'd10;
  localparam logic [3:0] KIND_ERROR  = 4'd11;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_CONST_ALPHA = 2'd1;
  localparam logic [1:0] ERR_BAD_CHAR    = 2'd2;

  localparam logic [1:0] KW_INT    = 2'd0;
  localparam logic [1:0] KW_RETURN = 2'd1;
  localparam logic [1:0] KW_VOID   = 2'd2;

  localparam int KW_LEN_INT    = 3;
  localparam int KW_LEN_RETURN = 6;
  localparam int KW_LEN_VOID   = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_USCORE  = 8'h5f;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;

  // Character of keyword k at position idx; zero past the end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [47:0] txt;
    case (k)
      KW_INT:    txt = {24'h0, "tni"};
      KW_RETURN: txt = "nruter";
      KW_VOID:   txt = {16'h0, "diov"};
      default:   txt = '0;
    endcase
    if (idx < 3'd6) kw_char = txt[{idx, 3'b000} +: 8];
    else kw_char = 8'h00;
  endfunction

endpackage
`default_nettype wire

// ===== design/cst_scan.sv =====
`default_nettype none
module cst_scan #(
  parameter int LINE_COUNTER_BITS   = cst_pkg::LINE_COUNTER_BITS_DEF,
  parameter int OFFSET_COUNTER_BITS = cst_pkg::OFFSET_COUNTER_BITS_DEF,
  parameter int LENGTH_BITS         = cst_pkg::LENGTH_BITS_DEF,
  parameter int DW = 4 + 2 + 8 + 2 * LINE_COUNTER_BITS + OFFSET_COUNTER_BITS + LENGTH_BITS + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [7:0]    src_byte,
  output logic      [1:0]    res_cnt,
  output logic      [DW-1:0] res0,
  output logic      [DW-1:0] res1
);
  import cst_pkg::*;

  localparam logic [LINE_COUNTER_BITS-1:0]   LMAX   = '1;
  localparam logic [OFFSET_COUNTER_BITS-1:0] OMAX   = '1;
  localparam logic [LENGTH_BITS-1:0]         LENMAX = '1;
  localparam logic [LINE_COUNTER_BITS-1:0]   LONE   = LINE_COUNTER_BITS'(1);
  localparam logic [LENGTH_BITS-1:0]         LENONE = LENGTH_BITS'(1);

  mode_t                          mode_r, mode_nxt;
  logic [2:0]                     kw_r, kw_nxt;
  logic [LENGTH_BITS-1:0]         len_r, len_nxt;
  logic [LINE_COUNTER_BITS-1:0]   pline_r, pline_nxt, pcol_r, pcol_nxt;
  logic [OFFSET_COUNTER_BITS-1:0] poff_r, poff_nxt;
  logic [LINE_COUNTER_BITS-1:0]   line_r, line_nxt, col_r, col_nxt;
  logic [OFFSET_COUNTER_BITS-1:0] off_r, off_nxt;

  logic                           is_alpha, is_digit, is_space, is_idc, is_ident;
  logic [LINE_COUNTER_BITS-1:0]   adv_line, adv_col;
  logic [OFFSET_COUNTER_BITS-1:0] adv_off;
  logic [LENGTH_BITS-1:0]         ext_len;
  logic [2:0]                     ext_kw, first_kw;
  logic [3:0]                     id_kind;

  logic       have_p, have_c, fall;
  logic [DW-1:0] p_res, c_res;
  logic [3:0] punct_kind;
  logic       is_punct;

  always_comb begin
    is_alpha = src_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    is_digit = src_byte inside {[8'h30:8'h39]};
    is_space = src_byte inside {8'h20, [8'h09:8'h0d]};
    is_idc   = is_alpha || (src_byte == CH_USCORE);
    is_ident = is_idc || is_digit;
  end

  // position after this byte, saturating
  always_comb begin
    if (src_byte == CH_NL) begin
      adv_line = (line_r != LMAX) ? line_r + LONE : line_r;
      adv_col  = LONE;
    end else begin
      adv_line = line_r;
      adv_col  = (col_r != LMAX) ? col_r + LONE : col_r;
    end
    adv_off = (off_r != OMAX) ? off_r + OFFSET_COUNTER_BITS'(1) : off_r;
  end

  always_comb begin
    ext_len = (len_r != LENMAX) ? len_r + LENONE : len_r;
    ext_kw[0] = kw_r[0] && (len_r < LENGTH_BITS'(KW_LEN_INT)) &&
                (src_byte == kw_char(KW_INT, len_r[2:0]));
    ext_kw[1] = kw_r[1] && (len_r < LENGTH_BITS'(KW_LEN_RETURN)) &&
                (src_byte == kw_char(KW_RETURN, len_r[2:0]));
    ext_kw[2] = kw_r[2] && (len_r < LENGTH_BITS'(KW_LEN_VOID)) &&
                (src_byte == kw_char(KW_VOID, len_r[2:0]));
    first_kw[0] = (src_byte == kw_char(KW_INT, 3'd0));
    first_kw[1] = (src_byte == kw_char(KW_RETURN, 3'd0));
    first_kw[2] = (src_byte == kw_char(KW_VOID, 3'd0));
    id_kind = KIND_IDENT;
    if (kw_r[0] && len_r == LENGTH_BITS'(KW_LEN_INT))    id_kind = KIND_INT;
    if (kw_r[1] && len_r == LENGTH_BITS'(KW_LEN_RETURN)) id_kind = KIND_RETURN;
    if (kw_r[2] && len_r == LENGTH_BITS'(KW_LEN_VOID))   id_kind = KIND_VOID;
  end

  always_comb begin
    is_punct = 1'b1;
    case (src_byte)
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_LPAREN: punct_kind = KIND_LPAREN;
      CH_RPAREN: punct_kind = KIND_RPAREN;
      default: begin
        punct_kind = KIND_ERROR;
        is_punct   = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    kw_nxt    = kw_r;
    len_nxt   = len_r;
    pline_nxt = pline_r;
    pcol_nxt  = pcol_r;
    poff_nxt  = poff_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    off_nxt   = off_r;
    have_p    = 1'b0;
    have_c    = 1'b0;
    fall      = 1'b0;
    p_res     = '0;
    c_res     = '0;

    // close or extend the pending token
    case (mode_r)
      MODE_IDENT: begin
        if (is_ident) begin
          kw_nxt   = ext_kw;
          len_nxt  = ext_len;
          line_nxt = adv_line;
          col_nxt  = adv_col;
          off_nxt  = adv_off;
        end else begin
          have_p   = 1'b1;
          p_res    = {id_kind, ERR_NONE, 8'h00, pline_r, pcol_r, poff_r, len_r, 1'b0};
          mode_nxt = MODE_IDLE;
          fall     = 1'b1;
        end
      end
      MODE_CONST: begin
        if (is_digit) begin
          kw_nxt   = ext_kw;
          len_nxt  = ext_len;
          line_nxt = adv_line;
          col_nxt  = adv_col;
          off_nxt  = adv_off;
        end else if (is_idc) begin
          have_p   = 1'b1;
          p_res    = {KIND_ERROR, ERR_CONST_ALPHA, src_byte, pline_r, pcol_r, poff_r,
                      {LENGTH_BITS{1'b0}}, 1'b0};
          mode_nxt = MODE_HALT;
        end else begin
          have_p   = 1'b1;
          p_res    = {KIND_CONST, ERR_NONE, 8'h00, pline_r, pcol_r, poff_r, len_r, 1'b0};
          mode_nxt = MODE_IDLE;
          fall     = 1'b1;
        end
      end
      MODE_IDLE: fall = 1'b1;
      default: ;
    endcase

    // the byte itself, as the start of what follows
    if (fall) begin
      if (is_space) begin
        line_nxt = adv_line;
        col_nxt  = adv_col;
        off_nxt  = adv_off;
      end else if (is_idc || is_digit) begin
        mode_nxt  = is_digit ? MODE_CONST : MODE_IDENT;
        kw_nxt    = first_kw;
        len_nxt   = LENONE;
        pline_nxt = line_r;
        pcol_nxt  = col_r;
        poff_nxt  = off_r;
        line_nxt  = adv_line;
        col_nxt   = adv_col;
        off_nxt   = adv_off;
      end else if (src_byte == CH_NUL) begin
        have_c   = 1'b1;
        c_res    = {KIND_END, ERR_NONE, 8'h00, line_r, col_r, off_r,
                    {LENGTH_BITS{1'b0}}, 1'b1};
        mode_nxt = MODE_HALT;
      end else if (is_punct) begin
        have_c   = 1'b1;
        c_res    = {punct_kind, ERR_NONE, 8'h00, line_r, col_r, off_r, LENONE, 1'b1};
        line_nxt = adv_line;
        col_nxt  = adv_col;
        off_nxt  = adv_off;
      end else begin
        have_c   = 1'b1;
        c_res    = {KIND_ERROR, ERR_BAD_CHAR, src_byte, line_r, col_r, off_r,
                    {LENGTH_BITS{1'b0}}, 1'b1};
        mode_nxt = MODE_HALT;
      end
    end

    res_cnt = {1'b0, have_p} + {1'b0, have_c};
    if (have_p) begin
      res0 = {p_res[DW-1:1], !have_c};
    end else begin
      res0 = c_res;
    end
    res1 = c_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      kw_r    <= 3'b111;
      len_r   <= '0;
      pline_r <= LONE;
      pcol_r  <= LONE;
      poff_r  <= '0;
      line_r  <= LONE;
      col_r   <= LONE;
      off_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      kw_r    <= kw_nxt;
      len_r   <= len_nxt;
      pline_r <= pline_nxt;
      pcol_r  <= pcol_nxt;
      poff_r  <= poff_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/cst_fifo.sv =====
`default_nettype none
module cst_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_cnt,
  input  wire logic [DW-1:0] din0,
  input  wire logic [DW-1:0] din1,
  input  wire logic          pop,
  output logic               room,
  output logic               not_empty,
  output logic      [DW-1:0] dout
);
  import cst_pkg::*;

  localparam int PW = $clog2(RESULT_QUEUE_DEPTH);

  logic [DW-1:0] q_r [RESULT_QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_plus1;
  logic [PW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_plus1  = wp_r + PW'(1);
    wp_nxt    = wp_r + PW'(push_cnt);
    rp_nxt    = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt   = cnt_r + (PW+1)'(push_cnt) - (PW+1)'(pop);
    // two free slots needed: one byte may close a token and give a result of its own
    room      = (cnt_r <= (PW+1)'(RESULT_QUEUE_DEPTH - 2));
    not_empty = (cnt_r != '0);
    dout      = q_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wp_r] <= din0;
    if (push_cnt == 2'd2) q_r[wp_plus1] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/c_subset_tokenizer_top.sv =====
// Minimal C-subset tokenizer. One source byte per request (0 = end of input);
// results carry kind, error code, offending byte, start line/column/offset
// and length, with last_of_run marking the final result caused by a byte.
// A byte is taken every cycle unless in_stall is high: it lands in an input
// register, is scanned against the token state, and its zero, one or two
// results go into a 4-entry result queue that drains one result per cycle
// while out_stall is low. A byte that closes an identifier or constant and is
// itself a punctuator, end or error gives two results; the input stalls only
// while the queue has fewer than two free entries, so a stream with at most
// one result per byte runs at one byte per cycle while results are taken as
// they come. After end of input or an error the block halts and swallows
// bytes until reset.
`default_nettype none
`include "c_subset_tokenizer_top_defines.svh"
module c_subset_tokenizer_top #(
  parameter int LINE_COUNTER_BITS   = cst_pkg::LINE_COUNTER_BITS_DEF,
  parameter int OFFSET_COUNTER_BITS = cst_pkg::OFFSET_COUNTER_BITS_DEF,
  parameter int LENGTH_BITS         = cst_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_source_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [3:0]                     out_token_kind,
  output logic      [1:0]                     out_error_code,
  output logic      [7:0]                     out_offending_byte,
  output logic      [LINE_COUNTER_BITS-1:0]   out_start_line,
  output logic      [LINE_COUNTER_BITS-1:0]   out_start_column,
  output logic      [OFFSET_COUNTER_BITS-1:0] out_start_offset,
  output logic      [LENGTH_BITS-1:0]         out_token_length,
  output logic                                out_last_of_run
);
  import cst_pkg::*;

  localparam int DW = 4 + 2 + 8 + 2 * LINE_COUNTER_BITS + OFFSET_COUNTER_BITS + LENGTH_BITS + 1;

  logic          in_vld_r, in_vld_nxt;
  logic [7:0]    in_byte_r;
  logic          accept, go, q_room, q_pop;
  logic [1:0]    res_cnt;
  logic [DW-1:0] res0, res1, q_dout;

  always_comb begin
    go         = in_vld_r && q_room;
    in_stall   = in_vld_r && !q_room;
    accept     = in_valid && !in_stall;
    in_vld_nxt = accept || (in_vld_r && !go);
    q_pop      = out_valid && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_byte_r <= in_source_byte;
  end

  cst_scan #(
    .LINE_COUNTER_BITS   (LINE_COUNTER_BITS),
    .OFFSET_COUNTER_BITS (OFFSET_COUNTER_BITS),
    .LENGTH_BITS         (LENGTH_BITS),
    .DW                  (DW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .src_byte (in_byte_r),
    .res_cnt  (res_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  cst_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (go ? res_cnt : 2'd0),
    .din0      (res0),
    .din1      (res1),
    .pop       (q_pop),
    .room      (q_room),
    .not_empty (out_valid),
    .dout      (q_dout)
  );

  assign {out_token_kind, out_error_code, out_offending_byte, out_start_line,
          out_start_column, out_start_offset, out_token_length, out_last_of_run} = q_dout;

  `CST_ASSERT_NEXT(a_result_reaches_output, go && (res_cnt != 2'd0), out_valid, "result lost")
  `CST_ASSERT_NOW(a_end_is_last, out_valid && (out_token_kind == KIND_END), out_last_of_run, "end not last")
  `CST_ASSERT_NOW(a_error_kind, out_valid && (out_error_code != ERR_NONE), out_token_kind == KIND_ERROR, "error code on non-error")
  `CST_ASSERT_NOW(a_pair_order, go && (res_cnt == 2'd2), res0[DW-1 -: 4] <= KIND_VOID, "pending token not first")

endmodule
`default_nettype wire

// ===== tb/sv/tokenizer_checker.sv =====
`timescale 1ns / 100ps
module tokenizer_checker #(
  parameter int LW = cst_pkg::LINE_COUNTER_BITS_DEF,
  parameter int OW = cst_pkg::OFFSET_COUNTER_BITS_DEF,
  parameter int NW = cst_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    in_source_byte,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [3:0]    out_token_kind,
  input  logic [1:0]    out_error_code,
  input  logic [7:0]    out_offending_byte,
  input  logic [LW-1:0] out_start_line,
  input  logic [LW-1:0] out_start_column,
  input  logic [OW-1:0] out_start_offset,
  input  logic [NW-1:0] out_token_length,
  input  logic          out_last_of_run,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output logic [11:0]   kinds_seen
);
  import cst_pkg::*;

  typedef struct {
    logic [3:0]    kind;
    logic [1:0]    code;
    logic [7:0]    offender;
    logic [LW-1:0] line;
    logic [LW-1:0] column;
    logic [OW-1:0] offset;
    logic [NW-1:0] length;
    logic          last;
  } token_t;

  localparam logic [LW-1:0] LINE_TOP = '1;
  localparam logic [OW-1:0] OFF_TOP  = '1;
  localparam logic [NW-1:0] LEN_TOP  = '1;

  string kw_word[3] = '{"int", "return", "void"};
  int    kw_size[3] = '{KW_LEN_INT, KW_LEN_RETURN, KW_LEN_VOID};

  token_t expected_tokens[$];

  mode_t         scan_mode;
  logic [2:0]    kw_live;
  logic [NW-1:0] tok_len;
  logic [LW-1:0] tok_line, tok_col, cur_line, cur_col;
  logic [OW-1:0] tok_off, cur_off;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    kinds_seen = '0;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_name_start(input logic [7:0] c);
    return is_letter(c) || c == CH_USCORE;
  endfunction

  task automatic queue_token(input logic [3:0] kind, input logic [1:0] code,
                             input logic [7:0] offender, input logic [LW-1:0] line,
                             input logic [LW-1:0] column, input logic [OW-1:0] offset,
                             input logic [NW-1:0] length);
    token_t t;
    t.kind     = kind;
    t.code     = code;
    t.offender = offender;
    t.line     = line;
    t.column   = column;
    t.offset   = offset;
    t.length   = length;
    t.last     = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic move_on(input logic [7:0] c);
    if (c == CH_NL) begin
      if (cur_line != LINE_TOP) cur_line++;
      cur_col = LW'(1);
    end else if (cur_col != LINE_TOP) begin
      cur_col++;
    end
    if (cur_off != OFF_TOP) cur_off++;
  endtask

  task automatic open_token(input mode_t m, input logic [7:0] c);
    scan_mode = m;
    tok_line  = cur_line;
    tok_col   = cur_col;
    tok_off   = cur_off;
    tok_len   = NW'(1);
    kw_live   = '0;
    for (int i = 0; i < 3; i++)
      if (kw_word[i][0] == c) kw_live[i] = 1'b1;
  endtask

  task automatic grow_token(input logic [7:0] c);
    for (int i = 0; i < 3; i++)
      if (!(int'(tok_len) < kw_size[i] && kw_word[i][int'(tok_len)] == c)) kw_live[i] = 1'b0;
    if (tok_len != LEN_TOP) tok_len++;
  endtask

  // works out the zero, one or two tokens that one source byte releases
  task automatic scan_source_byte(input logic [7:0] c);
    int         count_before;
    logic [3:0] kind;
    token_t     t;
    count_before = expected_tokens.size();
    if (scan_mode == MODE_HALT) return;

    if (scan_mode == MODE_IDENT) begin
      if (is_name_start(c) || is_num(c)) begin
        grow_token(c);
        move_on(c);
        return;
      end
      kind = KIND_IDENT;
      for (int i = 0; i < 3; i++)
        if (kw_live[i] && int'(tok_len) == kw_size[i]) kind = KIND_INT + 4'(i);
      queue_token(kind, ERR_NONE, 8'h00, tok_line, tok_col, tok_off, tok_len);
      scan_mode = MODE_IDLE;
    end else if (scan_mode == MODE_CONST) begin
      if (is_num(c)) begin
        grow_token(c);
        move_on(c);
        return;
      end
      if (is_name_start(c)) begin
        // error reported at the start of the constant
        queue_token(KIND_ERROR, ERR_CONST_ALPHA, c, tok_line, tok_col, tok_off, '0);
        scan_mode = MODE_HALT;
      end else begin
        queue_token(KIND_CONST, ERR_NONE, 8'h00, tok_line, tok_col, tok_off, tok_len);
        scan_mode = MODE_IDLE;
      end
    end

    if (scan_mode != MODE_HALT) begin
      if (is_blank(c)) begin
        move_on(c);
      end else if (is_name_start(c)) begin
        open_token(MODE_IDENT, c);
        move_on(c);
      end else if (is_num(c)) begin
        open_token(MODE_CONST, c);
        move_on(c);
      end else if (c == CH_NUL) begin
        queue_token(KIND_END, ERR_NONE, 8'h00, cur_line, cur_col, cur_off, '0);
        scan_mode = MODE_HALT;
      end else begin
        case (c)
          CH_SEMI:   kind = KIND_SEMI;
          CH_LBRACE: kind = KIND_LBRACE;
          CH_RBRACE: kind = KIND_RBRACE;
          CH_LPAREN: kind = KIND_LPAREN;
          CH_RPAREN: kind = KIND_RPAREN;
          default:   kind = KIND_ERROR;
        endcase
        if (kind != KIND_ERROR) begin
          queue_token(kind, ERR_NONE, 8'h00, cur_line, cur_col, cur_off, NW'(1));
          move_on(c);
        end else begin
          queue_token(KIND_ERROR, ERR_BAD_CHAR, c, cur_line, cur_col, cur_off, '0);
          scan_mode = MODE_HALT;
        end
      end
    end

    if (expected_tokens.size() > count_before) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      scan_mode = MODE_IDLE;
      kw_live   = 3'b111;
      tok_len   = '0;
      tok_line  = LW'(1);
      tok_col   = LW'(1);
      tok_off   = '0;
      cur_line  = LW'(1);
      cur_col   = LW'(1);
      cur_off   = '0;
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall) scan_source_byte(in_source_byte);
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got kind %0d at %0d:%0d",
                   $time, out_token_kind, out_start_line, out_start_column);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(out_token_kind));
          check_field("error_code", 32'(want.code), 32'(out_error_code));
          check_field("offending_byte", 32'(want.offender), 32'(out_offending_byte));
          check_field("start_line", 32'(want.line), 32'(out_start_line));
          check_field("start_column", 32'(want.column), 32'(out_start_column));
          check_field("start_offset", 32'(want.offset), 32'(out_start_offset));
          check_field("token_length", 32'(want.length), 32'(out_token_length));
          check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
          kinds_seen[want.kind] = 1'b1;
          checked++;
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

// ===== tb/sv/c_subset_tokenizer_top_tb.sv =====
`timescale 1ns / 100ps
module c_subset_tokenizer_top_tb;
  import cst_pkg::*;

  localparam int LW           = LINE_COUNTER_BITS_DEF;
  localparam int OW           = OFFSET_COUNTER_BITS_DEF;
  localparam int NW           = LENGTH_BITS_DEF;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_BYTES = 560;
  localparam int BLANK_RUN    = 30;

  typedef enum {STOP_EOF, STOP_BAD_BYTE, STOP_CONST_LETTER} stop_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [7:0]    in_source_byte;
  logic          out_valid;
  logic          out_stall;
  logic [3:0]    out_token_kind;
  logic [1:0]    out_error_code;
  logic [7:0]    out_offending_byte;
  logic [LW-1:0] out_start_line;
  logic [LW-1:0] out_start_column;
  logic [OW-1:0] out_start_offset;
  logic [NW-1:0] out_token_length;
  logic          out_last_of_run;

  int          fail_count, pending, checked;
  logic [11:0] kinds_seen;

  int    gap_max = 12;
  int    stall_max = 12;
  int    bytes_sent = 0;
  int    idle_cycles = 0;
  bit    hold_req = 1'b0;
  bit    word_open = 1'b0;
  bit    number_open = 1'b0;
  stop_t stop_kind;

  string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string name_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digit_chars = "0123456789";
  string junk_chars = "!\"#$%&'*+,-./:<=>?@[\\]^`|~";
  string kw_like[12] = '{"int", "return", "void", "in", "retu", "voi", "intx", "returns",
                         "void_", "Int", "vOid", "r"};
  logic [7:0] punct_set[5] = '{CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN};
  logic [7:0] blank_set[6] = '{8'h20, 8'h09, CH_NL, 8'h0b, 8'h0c, 8'h0d};
  logic [7:0] flat_blank[5] = '{8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  c_subset_tokenizer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_byte     (in_source_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_error_code     (out_error_code),
    .out_offending_byte (out_offending_byte),
    .out_start_line     (out_start_line),
    .out_start_column   (out_start_column),
    .out_start_offset   (out_start_offset),
    .out_token_length   (out_token_length),
    .out_last_of_run    (out_last_of_run)
  );

  tokenizer_checker token_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_byte     (in_source_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_error_code     (out_error_code),
    .out_offending_byte (out_offending_byte),
    .out_start_line     (out_start_line),
    .out_start_column   (out_start_column),
    .out_start_offset   (out_start_offset),
    .out_token_length   (out_token_length),
    .out_last_of_run    (out_last_of_run),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked),
    .kinds_seen         (kinds_seen)
  );

  // one request per source byte; payload held while stalled
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_sep(input logic [7:0] b);
    send_byte(b);
    word_open   = 1'b0;
    number_open = 1'b0;
  endtask

  // a letter straight after a constant would halt the scanner, so split them
  task automatic send_word(input string w);
    if (number_open) send_sep(8'h20);
    for (int i = 0; i < w.len(); i++) send_byte(w[i]);
    word_open   = 1'b1;
    number_open = 1'b0;
  endtask

  task automatic send_number(input int digits);
    for (int i = 0; i < digits; i++) send_byte(digit_chars[$urandom_range(9, 0)]);
    if (!word_open) number_open = 1'b1;
  endtask

  function automatic string random_word(input int n);
    string w;
    w = string'(name_head[$urandom_range(52, 0)]);
    for (int i = 1; i < n; i++) w = {w, string'(name_tail[$urandom_range(62, 0)])};
    return w;
  endfunction

  function automatic logic [7:0] pick_bad_byte();
    case ($urandom_range(3, 0))
      0:       return 8'($urandom_range(255, 128));
      1:       return 8'($urandom_range(8, 1));
      2:       return 8'($urandom_range(31, 14));
      default: return junk_chars[$urandom_range(junk_chars.len() - 1, 0)];
    endcase
  endfunction

  // result side: random stalls per result, plus one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = $urandom_range(stall_max, 0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    string directed;
    string w;
    int    random_start;
    int    r;
    bit    pressure_done;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_source_byte <= CH_NUL;
    pressure_done  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every keyword and punctuator, keyword followed directly by a bracket
    directed = "int(void){return 0;}\n_Zz9\t";
    for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);

    // length saturation on an identifier and on a constant
    w = random_word(300);
    send_word(w);
    send_sep(8'h20);
    send_number(280);
    send_sep(CH_SEMI);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      case (((bytes_sent - random_start) / 100) % 4)
        0: begin gap_max = 12; stall_max = 12; end
        1: begin gap_max = 0;  stall_max = 0;  end
        2: begin gap_max = 12; stall_max = 0;  end
        default: begin gap_max = 0; stall_max = 12; end
      endcase
      if (!pressure_done && bytes_sent - random_start >= 200) begin
        // receiver holds off while name;name;... keeps two tokens per separator
        pressure_done = 1'b1;
        hold_req = 1'b1;
        gap_max = 0;
        repeat (40) begin
          send_word(random_word($urandom_range(3, 1)));
          send_sep(punct_set[$urandom_range(4, 0)]);
        end
      end
      r = $urandom_range(99, 0);
      if (r < 25) send_word(random_word($urandom_range(8, 1)));
      else if (r < 35) send_word(kw_like[$urandom_range(11, 0)]);
      else if (r < 50) send_number($urandom_range(5, 1));
      else if (r < 75) send_sep(punct_set[$urandom_range(4, 0)]);
      else if (r < 90) send_sep(blank_set[$urandom_range(5, 0)]);
      else begin
        case ($urandom_range(3, 0))
          0:       send_word(random_word(1));
          1:       send_number(1);
          2:       send_sep(punct_set[$urandom_range(4, 0)]);
          default: send_sep(blank_set[$urandom_range(5, 0)]);
        endcase
      end
    end

    // long runs of blanks, then of newlines, back to back
    gap_max   = 0;
    stall_max = 0;
    send_sep(CH_NL);
    repeat (BLANK_RUN) send_sep(flat_blank[$urandom_range(4, 0)]);
    send_word("colmax");
    send_sep(CH_SEMI);
    repeat (BLANK_RUN) send_sep(CH_NL);
    send_word("linemax");
    send_number(2);
    send_sep(CH_RPAREN);

    gap_max   = 12;
    stall_max = 12;
    stop_kind = stop_t'($urandom_range(2, 0));
    case (stop_kind)
      STOP_EOF:      send_byte(CH_NUL);
      STOP_BAD_BYTE: send_byte(pick_bad_byte());
      default: begin
        send_sep(8'h20);
        send_number(3);
        send_byte(name_head[$urandom_range(52, 0)]);
      end
    endcase

    // halted: all of these must be swallowed
    send_byte(CH_NUL);
    send_byte(8'hff);
    send_byte(8'h80);
    repeat (12) send_byte(8'($urandom_range(255, 0)));
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);

    $display("Scanned %0d source bytes, checked %0d results, token kinds seen %b",
             bytes_sent, checked, kinds_seen);
    $display("Length saturation, a long receiver hold-off and halting covered; closed by %s",
             stop_kind.name());
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
